FILE: sv/siol_pkg.sv
// Shared constants and types for the second-order IIR low-pass unit.
`default_nettype none

package siol_pkg;

   localparam int COEF_BITS   = 15;
   localparam int Q_SHIFT     = 14;
   localparam int OUT_BITS    = 18;
   localparam int INDEX_BITS  = 2;

   localparam int SAMPLE_BITS_DEFAULT = 12;
   localparam int ACC_BITS_DEFAULT    = 32;

   localparam logic [INDEX_BITS-1:0] REG_FEEDBACK_ONE = 2'd0;
   localparam logic [INDEX_BITS-1:0] REG_FEEDBACK_TWO = 2'd1;
   localparam logic [INDEX_BITS-1:0] REG_INPUT_GAIN   = 2'd2;

   localparam logic [COEF_BITS-1:0] RESET_FEEDBACK_ONE = 15'd32047;
   localparam logic [COEF_BITS-1:0] RESET_FEEDBACK_TWO = 15'd15679;
   localparam logic [COEF_BITS-1:0] RESET_INPUT_GAIN   = 15'd4;

   typedef struct packed {
      logic [COEF_BITS-1:0] feedback_one;
      logic [COEF_BITS-1:0] feedback_two;
      logic [COEF_BITS-1:0] input_gain;
   } coef_type;

endpackage

`default_nettype wire

FILE: sv/second_order_iir_lowpass_unit.sv
// Top level of the second-order IIR low-pass unit: handshake and stage control.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall   req_sample   (SAMPLE_BITS, unsigned)
//   rsp_     out        rsp_valid/rsp_stall   rsp_filtered (18 bits, signed)
//   csr_     in         csr_write             csr_index, csr_data (15 bits)
//
// One item per cycle sustained while rsp_stall is low; an item passes through the
// input register and then the output register. The figure is set by the feedback
// path: both feedback products, the gain product and the 3-input sum settle combinationally into the output history.
// Reset clears the history and loads the default coefficients; no sweep.
// A stalled result holds in the output register; the input register keeps
// taking items until both registers are full.
`default_nettype none

module second_order_iir_lowpass_unit #(
   parameter int SAMPLE_BITS = siol_pkg::SAMPLE_BITS_DEFAULT,
   parameter int ACC_BITS    = siol_pkg::ACC_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [SAMPLE_BITS-1:0]              req_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [siol_pkg::OUT_BITS-1:0]     rsp_filtered,
   input  wire logic                                csr_write,
   input  wire logic [siol_pkg::INDEX_BITS-1:0]     csr_index,
   input  wire logic [siol_pkg::COEF_BITS-1:0]      csr_data
);
   import siol_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic                   advance;
   logic                   accept;
   coef_type               coef;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_sample;
      end
   end

   siol_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef)
   );

   siol_core #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_BITS    (ACC_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .sample   (sample_ff),
      .coef     (coef),
      .filtered (rsp_filtered)
   );

   assign rsp_valid = out_valid_ff;

   // an item that moves into the output register shows up as a result
   assert property (@(posedge clock) disable iff (reset) advance |=> rsp_valid)
      else $error("item advanced but no result presented");

   // a held item in the input register is neither lost nor overwritten
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(sample_ff)))
      else $error("held input item lost or changed");

   // a result only appears when an item was waiting in the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(in_valid_ff))
      else $error("result appeared without an item");

   // a taken result with nothing behind it leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !in_valid_ff) |=> !rsp_valid)
      else $error("result repeated");

endmodule

`default_nettype wire

FILE: sv/siol_csr.sv
// Coefficient registers written through the configuration port.
`default_nettype none

module siol_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write,
   input  wire logic [siol_pkg::INDEX_BITS-1:0] csr_index,
   input  wire logic [siol_pkg::COEF_BITS-1:0]  csr_data,
   output siol_pkg::coef_type                   coef
);
   import siol_pkg::*;

   coef_type coef_ff, coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_FEEDBACK_ONE: coef_in.feedback_one = csr_data;
            REG_FEEDBACK_TWO: coef_in.feedback_two = csr_data;
            REG_INPUT_GAIN:   coef_in.input_gain   = csr_data;
            default:          coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.feedback_one <= RESET_FEEDBACK_ONE;
         coef_ff.feedback_two <= RESET_FEEDBACK_TWO;
         coef_ff.input_gain   <= RESET_INPUT_GAIN;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

`default_nettype wire

FILE: sv/siol_core.sv
// Filter datapath: sample and output history plus the single-pass Q14 update.
`default_nettype none

module siol_core #(
   parameter int SAMPLE_BITS = siol_pkg::SAMPLE_BITS_DEFAULT,
   parameter int ACC_BITS    = siol_pkg::ACC_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire logic [SAMPLE_BITS-1:0]              sample,
   input  wire siol_pkg::coef_type                  coef,
   output logic signed [siol_pkg::OUT_BITS-1:0]     filtered
);
   import siol_pkg::*;

   localparam int BINOM_BITS = SAMPLE_BITS + 2;
   localparam int GAIN_BITS  = COEF_BITS + BINOM_BITS;
   localparam int GAIN_WIDE  = (GAIN_BITS > ACC_BITS) ? GAIN_BITS : ACC_BITS;
   localparam int PROD_BITS  = ACC_BITS + COEF_BITS + 1;
   localparam int SHIFT_BITS = ACC_BITS - Q_SHIFT;
   localparam int SHIFT_WIDE = (SHIFT_BITS > OUT_BITS) ? SHIFT_BITS : OUT_BITS;

   logic [SAMPLE_BITS-1:0] last_sample_ff, older_sample_ff;
   logic [ACC_BITS-1:0]    last_output_ff, older_output_ff;
   logic [OUT_BITS-1:0]    filtered_ff, filtered_in;

   logic [BINOM_BITS-1:0]        binomial;
   logic [GAIN_WIDE-1:0]         gain_product;
   logic signed [PROD_BITS-1:0]  product_one, product_two;
   logic [ACC_BITS-1:0]          acc;
   logic signed [SHIFT_WIDE-1:0] acc_shifted;

   always_comb begin
      binomial = BINOM_BITS'(sample)
               + BINOM_BITS'({last_sample_ff, 1'b0})
               + BINOM_BITS'(older_sample_ff);
      gain_product = GAIN_WIDE'(coef.input_gain) * GAIN_WIDE'(binomial);
      // signed history times unsigned coefficient; dropping 14 bits floors
      product_one = PROD_BITS'($signed(last_output_ff))
                  * PROD_BITS'($signed({1'b0, coef.feedback_one}));
      product_two = PROD_BITS'($signed(older_output_ff))
                  * PROD_BITS'($signed({1'b0, coef.feedback_two}));
      acc = gain_product[ACC_BITS-1:0]
          + product_one[ACC_BITS+Q_SHIFT-1:Q_SHIFT]
          - product_two[ACC_BITS+Q_SHIFT-1:Q_SHIFT];
      acc_shifted = SHIFT_WIDE'($signed(acc[ACC_BITS-1:Q_SHIFT]));
      filtered_in = acc_shifted[OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_ff  <= '0;
         older_sample_ff <= '0;
         last_output_ff  <= '0;
         older_output_ff <= '0;
      end else if (advance) begin
         last_sample_ff  <= sample;
         older_sample_ff <= last_sample_ff;
         last_output_ff  <= acc;
         older_output_ff <= last_output_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         filtered_ff <= filtered_in;
      end
   end

   assign filtered = $signed(filtered_ff);

endmodule

`default_nettype wire
